// ===== hw/rtl/ldht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldht package
// shared types and constants of the loiter direction histogram tracker
// ----------------------------------------------------------------------------
package ldht_pkg;

  localparam int NUM_BINS       = 8;
  localparam int SECTOR_DEGREES = 45;
  localparam int LAST_BIN       = 7;
  localparam int DWELL_W        = 16;
  localparam int ID_W           = 32;
  localparam int HEAD_W         = 9;
  localparam int PCT_W          = 7;
  localparam int FREED_W        = 6;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd70;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_SWEEP   = 1'b1;

  // one queued request between front and back
  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   target_id;
    logic [2:0]        bin;
    logic [DWELL_W-1:0] min_dwell;
    logic              judge_enable;
  } req_t;

  // heading to bin, clamped to the last bin
  function automatic logic [2:0] heading_bin(input logic [HEAD_W-1:0] h);
    logic [2:0] b;
    b = 3'(LAST_BIN);
    if (h < 9'(SECTOR_DEGREES * 1)) b = 3'd0;
    else if (h < 9'(SECTOR_DEGREES * 2)) b = 3'd1;
    else if (h < 9'(SECTOR_DEGREES * 3)) b = 3'd2;
    else if (h < 9'(SECTOR_DEGREES * 4)) b = 3'd3;
    else if (h < 9'(SECTOR_DEGREES * 5)) b = 3'd4;
    else if (h < 9'(SECTOR_DEGREES * 6)) b = 3'd5;
    else if (h < 9'(SECTOR_DEGREES * 7)) b = 3'd6;
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ldht_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldht front
// accepts requests, bins the heading and holds them in a two-deep queue
// ----------------------------------------------------------------------------
module ldht_front import ldht_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_cmd,
  input  wire logic [ID_W-1:0] in_id,
  input  wire logic [HEAD_W-1:0] in_heading,
  input  wire logic [DWELL_W-1:0] in_min_dwell,
  input  wire logic            in_enable,
  output logic                 q_valid,
  input  wire logic            q_take,
  output req_t                 q_req
);

  req_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  req_t       req_in;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot[rd_ptr];

  // classify incoming request
  always_comb begin
    req_in.cmd          = in_cmd;
    req_in.target_id    = in_id;
    req_in.bin          = heading_bin(in_heading);
    req_in.min_dwell    = in_min_dwell;
    req_in.judge_enable = in_enable;
  end

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wr_ptr] <= req_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(in_valid && in_ready) - 2'(q_take);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ldht_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldht back
// searches the target table, updates histograms, judges and sweeps
// ----------------------------------------------------------------------------
module ldht_back import ldht_pkg::*; #(
  parameter int TABLE_ENTRIES = 32,
  parameter int BIN_WIDTH     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [PCT_W-1:0]   pct,
  input  wire logic               q_valid,
  output logic                    q_take,
  input  req_t                    q_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_loiter,
  output logic                    out_full,
  output logic [FREED_W-1:0]      out_freed
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SUM_W = BIN_WIDTH + 3;
  localparam int PROD_W = SUM_W + PCT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_JUDGE  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state;

  // table; valid and seen bits are reset flops, other fields rewritten on claim
  logic [TABLE_ENTRIES-1:0] valid, seen;
  logic [ID_W-1:0]    tgt   [TABLE_ENTRIES];
  logic [DWELL_W-1:0] dwell [TABLE_ENTRIES];
  logic [BIN_WIDTH-1:0] hist [TABLE_ENTRIES][NUM_BINS];

  req_t req;
  logic [IDX_W-1:0] idx;
  logic [BIN_WIDTH-1:0] h [NUM_BINS];
  logic [DWELL_W-1:0]   dw;
  logic [SUM_W-1:0]     sector, total;

  // associative match and free search
  logic             hit, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; free_any = 1'b0;
    hit_idx = '0; free_idx = '0;
    for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
      if (valid[e] && tgt[e] == q_req.target_id) begin
        hit = 1'b1; hit_idx = IDX_W'(e);
      end
      if (!valid[e]) begin
        free_any = 1'b1; free_idx = IDX_W'(e);
      end
    end
  end

  // request classes seen at the head of the queue
  logic judge_req, upd_go, full_n;
  assign judge_req = (q_req.cmd == CMD_OBSERVE) && q_req.judge_enable;
  assign upd_go    = judge_req && (hit || free_any);
  assign full_n    = judge_req && !hit && !free_any;

  // freed count of a sweep
  logic [FREED_W-1:0] freed_n;
  logic [TABLE_ENTRIES-1:0] drop;
  always_comb begin
    drop = valid & ~seen;
    if ($countones(drop) > 63) freed_n = 6'd63;
    else freed_n = FREED_W'($countones(drop));
  end

  // dominant bin search over eight bins
  logic [BIN_WIDTH-1:0] best;
  logic [2:0] best_i;
  logic [SUM_W-1:0] tot_c;
  always_comb begin
    best = '0; best_i = '0; tot_c = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      tot_c = tot_c + SUM_W'(h[i]);
      if (best < h[i]) begin
        best = h[i]; best_i = 3'(i);
      end
    end
  end

  assign q_take    = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      seen  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            req        <= q_req;
            out_loiter <= 1'b0;
            out_full   <= full_n;
            out_freed  <= (q_req.cmd == CMD_SWEEP) ? freed_n : '0;
            state      <= upd_go ? S_UPDATE : S_OUT;
            if (q_req.cmd == CMD_SWEEP) begin
              valid     <= valid & ~drop;
              seen      <= '0;
            end else if (!q_req.judge_enable) begin
              if (hit) seen[hit_idx] <= 1'b1;
            end else if (hit) begin
              idx <= hit_idx;
              seen[hit_idx] <= 1'b1;
            end else if (free_any) begin
              idx <= free_idx;
              valid[free_idx] <= 1'b1;
              seen[free_idx]  <= 1'b1;
              tgt[free_idx]   <= q_req.target_id;
              dwell[free_idx] <= '0;
              for (int i = 0; i < NUM_BINS; i++) hist[free_idx][i] <= '0;
            end
          end
        end
        S_UPDATE: begin
          // saturating increments, copy entry to working registers
          for (int i = 0; i < NUM_BINS; i++) begin
            if (3'(i) == req.bin && hist[idx][i] != {BIN_WIDTH{1'b1}})
              h[i] <= hist[idx][i] + 1'b1;
            else
              h[i] <= hist[idx][i];
          end
          if (hist[idx][req.bin] != {BIN_WIDTH{1'b1}})
            hist[idx][req.bin] <= hist[idx][req.bin] + 1'b1;
          if (dwell[idx] != {DWELL_W{1'b1}}) begin
            dw <= dwell[idx] + 1'b1;
            dwell[idx] <= dwell[idx] + 1'b1;
          end else begin
            dw <= dwell[idx];
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          total  <= tot_c;
          sector <= SUM_W'(best) + SUM_W'(h[best_i - 3'd1]) + SUM_W'(h[best_i + 3'd1]);
          state  <= S_JUDGE;
        end
        S_JUDGE: begin
          out_loiter <= (PROD_W'(sector) * PROD_W'(100) < PROD_W'(total) * PROD_W'(pct))
                        && (dw >= req.min_dwell);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/loiter_direction_histogram_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// loiter direction histogram tracker
// per-target direction histograms with loiter judging and frame sweeps
// ----------------------------------------------------------------------------
// An observation that updates a histogram runs the back-end steps lookup,
// increment, bin search, judge and result; presence-only, table-full and sweep
// requests go from lookup to result. The back end handles one request at
// a time and the two-deep queue in front keeps accepting while a result waits.
module loiter_direction_histogram_tracker import ldht_pkg::*; #(
  parameter int TABLE_ENTRIES = 32,
  parameter int BIN_WIDTH     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,       // dominance_percent [6:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // target_id, heading_degrees, min_dwell, judge_enable
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // loiter_flag, table_full, freed_count
  output logic [0:0]       m_axis_tuser    // unused, zero
);

  logic [PCT_W-1:0] pct;
  logic q_valid, q_take;
  req_t q_req;
  logic loiter, full;
  logic [FREED_W-1:0] freed;

  assign cfg_ready = 1'b1;
  // configuration register
  always_ff @(posedge clk) begin
    if (rst) pct <= PCT_RESET;
    else if (cfg_valid) pct <= cfg_data[PCT_W-1:0];
  end

  ldht_front u_front (
    .clk, .rst,
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_cmd       (s_axis_tuser),
    .in_id        (s_axis_tdata[31:0]),
    .in_heading   (s_axis_tdata[40:32]),
    .in_min_dwell (s_axis_tdata[56:41]),
    .in_enable    (s_axis_tdata[57]),
    .q_valid, .q_take, .q_req
  );

  ldht_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .BIN_WIDTH(BIN_WIDTH)) u_back (
    .clk, .rst, .pct,
    .q_valid, .q_take, .q_req,
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_loiter (loiter),
    .out_full   (full),
    .out_freed  (freed)
  );

  assign m_axis_tdata = {freed, full, loiter};
  assign m_axis_tuser = 1'b0;

endmodule
`default_nettype wire

// ===== dv/ldht_checker.sv =====
// ----------------------------------------------------------------------------
// ldht checker
// watches the request, result and config channels of the loiter tracker,
// predicts each result from its own copy of the target table and compares
// ----------------------------------------------------------------------------
module ldht_checker import ldht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  output int               fail_count,
  output int               pending,
  output int               loiter_seen,
  output int               full_seen,
  output int               freed_seen
);

  localparam int ENTRIES = 32;
  localparam int BIN_MAX = 255;

  typedef struct packed {
    logic [5:0] freed_count;
    logic       table_full;
    logic       loiter_flag;
  } verdict_t;

  logic [PCT_W-1:0]   dom_pct;
  logic               t_valid [ENTRIES];
  logic [ID_W-1:0]    t_id    [ENTRIES];
  logic [DWELL_W-1:0] t_dwell [ENTRIES];
  logic [7:0]         t_bins  [ENTRIES][NUM_BINS];
  logic               t_seen  [ENTRIES];
  verdict_t           verdict_q[$];

  assign pending = verdict_q.size();

  // judge one tracked target after updating its histogram
  function automatic logic judge_target(int e, logic [HEAD_W-1:0] hd, logic [15:0] mind);
    int b, total, best, best_i, sector;
    b = hd / 45;
    if (b > 7) b = 7;
    if (t_dwell[e] != 16'hFFFF) t_dwell[e]++;
    if (t_bins[e][b] != BIN_MAX) t_bins[e][b]++;
    total = 0; best = 0; best_i = 0;
    for (int i = 0; i < NUM_BINS; i++) begin
      total += t_bins[e][i];
      if (best < t_bins[e][i]) begin
        best = t_bins[e][i];
        best_i = i;
      end
    end
    sector = best + t_bins[e][(best_i + 7) % 8] + t_bins[e][(best_i + 1) % 8];
    return (sector * 100 < total * dom_pct) && (t_dwell[e] >= mind);
  endfunction

  // predict the result of one request
  function automatic verdict_t track_request(logic cmd, logic [63:0] d);
    verdict_t v;
    logic [31:0] id;
    int slot;
    v = '0;
    id = d[31:0];
    if (cmd == CMD_SWEEP) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if (t_valid[e] && !t_seen[e]) begin
          t_valid[e] = 0; t_id[e] = 0; t_dwell[e] = 0;
          for (int i = 0; i < NUM_BINS; i++) t_bins[e][i] = 0;
          if (v.freed_count != 63) v.freed_count++;
        end
        t_seen[e] = 0;
      end
    end else begin
      slot = -1;
      for (int e = ENTRIES - 1; e >= 0; e--)
        if (t_valid[e] && t_id[e] == id) slot = e;
      if (d[57]) begin
        if (slot < 0)
          for (int e = ENTRIES - 1; e >= 0; e--)
            if (!t_valid[e]) slot = e;
        if (slot < 0) v.table_full = 1;
        else begin
          if (!t_valid[slot]) begin
            t_valid[slot] = 1; t_id[slot] = id; t_dwell[slot] = 0;
            for (int i = 0; i < NUM_BINS; i++) t_bins[slot][i] = 0;
          end
          t_seen[slot] = 1;
          v.loiter_flag = judge_target(slot, d[40:32], d[56:41]);
        end
      end else if (slot >= 0) t_seen[slot] = 1;
    end
    return v;
  endfunction

  // follow requests, config writes and results
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      dom_pct <= PCT_RESET;
      for (int e = 0; e < ENTRIES; e++) begin
        t_valid[e] = 0; t_id[e] = 0; t_dwell[e] = 0; t_seen[e] = 0;
        for (int i = 0; i < NUM_BINS; i++) t_bins[e][i] = 0;
      end
      verdict_q.delete();
      fail_count <= 0;
      loiter_seen <= 0; full_seen <= 0; freed_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) dom_pct <= cfg_data[6:0];
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.push_back(track_request(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch loiter/full/freed expected %0d/%0d/%0d actual %0d/%0d/%0d",
                     $time, want.loiter_flag, want.table_full, want.freed_count,
                     got.loiter_flag, got.table_full, got.freed_count);
            fail_count <= fail_count + 1;
          end
          if (got.loiter_flag) loiter_seen <= loiter_seen + 1;
          if (got.table_full) full_seen <= full_seen + 1;
          if (got.freed_count != 0) freed_seen <= freed_seen + 1;
        end
      end
    end
  end

endmodule

// ===== dv/tb_loiter_direction_histogram_tracker.sv =====
// ----------------------------------------------------------------------------
// loiter tracker testbench
// directed and random observations and frame sweeps with bursty requests,
// stalled results and several dominance settings; checking in ldht_checker
// ----------------------------------------------------------------------------
module tb_loiter_direction_histogram_tracker import ldht_pkg::*;;

  localparam int WATCHDOG = 20000;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  int          fail_count, pending, loiter_seen, full_seen, freed_seen;
  int          idle_cycles, requests_sent;
  logic        hold_off, timed_out;
  logic [31:0] id_pool [16];

  loiter_direction_histogram_tracker dut (.*);

  ldht_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no request, result or config write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG && !timed_out) begin
      timed_out <= 1;
      $display("loiter_direction_histogram_tracker test failed");
      $finish;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) || (($time / 3000) % 2 == 0);
  end

  task automatic send_request(logic cmd, logic [31:0] id, logic [8:0] hd,
                              logic [15:0] mind, logic en);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, en, mind, hd, id};
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_percent(logic [6:0] pct);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= {1'b0, pct};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n, int ids);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0)
        send_request(CMD_SWEEP, $urandom, 9'($urandom), 16'($urandom), 1'($urandom));
      else if (k < 3)
        send_request(CMD_OBSERVE, $urandom, 9'($urandom), 16'($urandom), 1'($urandom));
      else
        send_request(CMD_OBSERVE, id_pool[$urandom_range(0, ids - 1)],
                     (k < 5) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 359)),
                     16'($urandom_range(0, 12)), k != 3);
    end
  endtask

  initial begin
    rst = 1; cfg_valid = 0; cfg_data = 0; hold_off = 0; timed_out = 0;
    s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
    requests_sent = 0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'h0; id_pool[1] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of every field, presence only, clamped heading
    send_request(CMD_OBSERVE, 32'h0, 9'd0, 16'd0, 1'b1);
    send_request(CMD_OBSERVE, 32'h0, 9'd511, 16'd0, 1'b1);
    send_request(CMD_OBSERVE, 32'h0, 9'd180, 16'd0, 1'b1);
    send_request(CMD_OBSERVE, 32'h0, 9'd90, 16'hFFFF, 1'b1);
    send_request(CMD_OBSERVE, 32'hFFFF_FFFF, 9'd359, 16'd1, 1'b1);
    send_request(CMD_OBSERVE, 32'h1234_5678, 9'd44, 16'd0, 1'b0);
    send_request(CMD_OBSERVE, 32'hFFFF_FFFF, 9'd45, 16'd0, 1'b0);
    send_request(CMD_SWEEP, 32'hFFFF_FFFF, 9'd511, 16'hFFFF, 1'b1);
    send_request(CMD_SWEEP, 32'h0, 9'd0, 16'd0, 1'b0);

    // fill the table, overflow it, then sweep it empty
    for (int i = 0; i < 34; i++)
      send_request(CMD_OBSERVE, 32'hA000_0000 + 32'(i), 9'(i * 15), 16'd0, 1'b1);
    send_request(CMD_SWEEP, 32'h0, 9'd0, 16'd0, 1'b0);
    send_request(CMD_SWEEP, 32'h0, 9'd0, 16'd0, 1'b0);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 4);
    join

    random_phase(100, 6);
    write_percent(7'd0);
    random_phase(40, 4);
    write_percent(7'd127);
    random_phase(60, 8);
    write_percent(7'd100);
    // bin saturation on one target
    for (int i = 0; i < 270; i++)
      send_request(CMD_OBSERVE, 32'h5A5A_5A5A, 9'd10, 16'd300, 1'b1);
    write_percent(7'($urandom_range(30, 95)));
    random_phase(65, 16);

    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d requests over five dominance settings", requests_sent);
    $display("results with loiter %0d, table full %0d, sweeps freeing %0d",
             loiter_seen, full_seen, freed_seen);
    if (fail_count == 0) $display("loiter_direction_histogram_tracker test passed");
    else $display("loiter_direction_histogram_tracker test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ldht_pkg.sv
hw/rtl/ldht_front.sv
hw/rtl/ldht_back.sv
hw/rtl/loiter_direction_histogram_tracker.sv
dv/ldht_checker.sv
dv/tb_loiter_direction_histogram_tracker.sv
